>>> src/scdl_pkg.sv
// Shared types and constants for the quarter-wave sine/cosine lookup core.
// Holds the 256-entry quarter-wave table, field widths and the pipeline control struct.
// No dependencies.
package scdl_pkg;

	localparam int ANGLE_W  = 10;
	localparam int MAG_W    = 10;
	localparam int OFS_W    = 7;
	localparam int IDX_W    = 8;
	localparam int WORD_W   = 16;
	localparam int RESULT_W = 17;

	localparam logic [MAG_W-1:0] QUAD_SPAN  = 10'd90;
	localparam logic [MAG_W-1:0] HALF_SPAN  = 10'd180;
	localparam logic [MAG_W-1:0] THREE_SPAN = 10'd270;
	localparam logic [MAG_W-1:0] FULL_SPAN  = 10'd360;

	// floor(r*17/6) is computed as (r*17*683) >> 12, exact for r in 0..90.
	localparam int IDX_MUL_W  = 21;
	localparam logic [13:0] IDX_MUL = 14'd11611;
	localparam int IDX_SHIFT  = 12;

	typedef struct packed {
		logic       valid;
		logic [1:0] quad;
		logic       neg;
		logic       oor;
	} ctl_t;

	localparam logic [WORD_W-1:0] QW_TABLE [256] = '{
		16'd0,16'd402,16'd804,16'd1206,16'd1608,16'd2010,16'd2412,16'd2814,16'd3216,16'd3617,
		16'd4019,16'd4420,16'd4821,16'd5222,16'd5623,16'd6023,16'd6424,16'd6824,16'd7223,
		16'd7623,16'd8022,16'd8421,16'd8820,16'd9218,16'd9616,16'd10014,16'd10411,16'd10808,
		16'd11204,16'd11600,16'd11996,16'd12391,16'd12785,16'd13179,16'd13573,16'd13966,
		16'd14359,16'd14751,16'd15142,16'd15533,16'd15924,16'd16313,16'd16703,16'd17091,
		16'd17479,16'd17866,16'd18253,16'd18639,16'd19024,16'd19408,16'd19792,16'd20175,
		16'd20557,16'd20939,16'd21319,16'd21699,16'd22078,16'd22456,16'd22834,16'd23210,
		16'd23586,16'd23960,16'd24334,16'd24707,16'd25079,16'd25450,16'd25820,16'd26189,
		16'd26557,16'd26925,16'd27291,16'd27656,16'd28020,16'd28383,16'd28745,16'd29106,
		16'd29465,16'd29824,16'd30181,16'd30538,16'd30893,16'd31247,16'd31600,16'd31952,
		16'd32302,16'd32651,16'd32999,16'd33346,16'd33692,16'd34036,16'd34379,16'd34721,
		16'd35061,16'd35400,16'd35738,16'd36074,16'd36409,16'd36743,16'd37075,16'd37406,
		16'd37736,16'd38064,16'd38390,16'd38715,16'd39039,16'd39361,16'd39682,16'd40001,
		16'd40319,16'd40635,16'd40950,16'd41263,16'd41575,16'd41885,16'd42194,16'd42500,
		16'd42806,16'd43109,16'd43411,16'd43712,16'd44011,16'd44308,16'd44603,16'd44897,
		16'd45189,16'd45479,16'd45768,16'd46055,16'd46340,16'd46624,16'd46905,16'd47185,
		16'd47464,16'd47740,16'd48014,16'd48287,16'd48558,16'd48827,16'd49095,16'd49360,
		16'd49624,16'd49885,16'd50145,16'd50403,16'd50659,16'd50913,16'd51166,16'd51416,
		16'd51664,16'd51911,16'd52155,16'd52398,16'd52638,16'd52877,16'd53113,16'd53348,
		16'd53580,16'd53811,16'd54039,16'd54266,16'd54490,16'd54713,16'd54933,16'd55151,
		16'd55367,16'd55582,16'd55794,16'd56003,16'd56211,16'd56417,16'd56620,16'd56822,
		16'd57021,16'd57218,16'd57413,16'd57606,16'd57797,16'd57985,16'd58171,16'd58356,
		16'd58537,16'd58717,16'd58895,16'd59070,16'd59243,16'd59414,16'd59582,16'd59749,
		16'd59913,16'd60075,16'd60234,16'd60391,16'd60546,16'd60699,16'd60850,16'd60998,
		16'd61144,16'd61287,16'd61429,16'd61567,16'd61704,16'd61838,16'd61970,16'd62100,
		16'd62227,16'd62352,16'd62475,16'd62595,16'd62713,16'd62829,16'd62942,16'd63053,
		16'd63161,16'd63267,16'd63371,16'd63472,16'd63571,16'd63668,16'd63762,16'd63853,
		16'd63943,16'd64030,16'd64114,16'd64196,16'd64276,16'd64353,16'd64428,16'd64500,
		16'd64570,16'd64638,16'd64703,16'd64765,16'd64826,16'd64883,16'd64939,16'd64992,
		16'd65042,16'd65090,16'd65136,16'd65179,16'd65219,16'd65258,16'd65293,16'd65327,
		16'd65357,16'd65386,16'd65412,16'd65435,16'd65456,16'd65475,16'd65491,16'd65504,
		16'd65515,16'd65524,16'd65530,16'd65533
	};

endpackage

>>> src/sine_cosine_degree_lut_core.sv
// Sine and cosine of a signed whole-degree angle from a quarter-wave table.
// Pipeline: fold, index + ROM read, sign; done is registered alongside the results.
// Throughput: one item per cycle; busy is always low and the result strobe cannot stall.
// Each result is held on the ports for exactly one cycle while done is high.
// Reset (arst_n low, asynchronous) clears the pipeline valid bits; no table clearing is needed.
// Depends on scdl_pkg and scdl_rom.
module sine_cosine_degree_lut_core
	import scdl_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [ANGLE_W-1:0]  angle_deg,
	output logic                       done,
	output logic signed [RESULT_W-1:0] sine_value,
	output logic signed [RESULT_W-1:0] cosine_value,
	output logic                       out_of_range
);

	logic             accept;
	logic             neg;
	logic [MAG_W-1:0] mag;
	logic [1:0]       quad;
	logic [MAG_W-1:0] ofs_full;
	ctl_t             ctl_in;

	ctl_t             ctl_s1;
	logic [OFS_W-1:0] ofs_s1;
	ctl_t             ctl_s2;

	logic [IDX_MUL_W-1:0] idx_prod;
	logic [IDX_W-1:0]     idx;
	logic [WORD_W-1:0]    t_dir;
	logic [WORD_W-1:0]    t_mir;

	logic [WORD_W-1:0]   s_mag;
	logic [WORD_W-1:0]   c_mag;
	logic                s_neg;
	logic                c_neg;
	logic [RESULT_W-1:0] s_word;
	logic [RESULT_W-1:0] c_word;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Fold the angle magnitude into a quadrant; boundary values go to the lower quadrant.
	assign neg = angle_deg[ANGLE_W-1];
	assign mag = neg ? (MAG_W'(0) - MAG_W'(angle_deg)) : MAG_W'(angle_deg);

	always_comb begin
		if (mag <= QUAD_SPAN) begin
			quad     = 2'd0;
			ofs_full = mag;
		end else if (mag <= HALF_SPAN) begin
			quad     = 2'd1;
			ofs_full = mag - QUAD_SPAN;
		end else if (mag <= THREE_SPAN) begin
			quad     = 2'd2;
			ofs_full = mag - HALF_SPAN;
		end else begin
			quad     = 2'd3;
			ofs_full = mag - THREE_SPAN;
		end
	end

	assign ctl_in = '{valid: accept, quad: quad, neg: neg, oor: (mag > FULL_SPAN)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done   <= 1'b0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			done   <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		ofs_s1 <= ofs_full[OFS_W-1:0];
	end

	assign idx_prod = IDX_MUL_W'(ofs_s1) * IDX_MUL_W'(IDX_MUL);
	assign idx      = idx_prod[IDX_SHIFT +: IDX_W];

	scdl_rom u_rom (
		.clk    (clk),
		.addr_a (idx),
		.addr_b (~idx),
		.data_a (t_dir),
		.data_b (t_mir)
	);

	// Odd quadrants swap the direct and mirrored words between sine and cosine.
	assign s_mag = ctl_s2.quad[0] ? t_mir : t_dir;
	assign c_mag = ctl_s2.quad[0] ? t_dir : t_mir;
	assign s_neg = ctl_s2.neg ^ ctl_s2.quad[1];
	assign c_neg = ctl_s2.quad[0] ^ ctl_s2.quad[1];
	assign s_word = s_neg ? (RESULT_W'(0) - RESULT_W'(s_mag)) : RESULT_W'(s_mag);
	assign c_word = c_neg ? (RESULT_W'(0) - RESULT_W'(c_mag)) : RESULT_W'(c_mag);

	always_ff @(posedge clk) begin
		if (ctl_s2.oor) begin
			sine_value   <= '0;
			cosine_value <= '0;
		end else begin
			sine_value   <= s_word;
			cosine_value <= c_word;
		end
		out_of_range <= ctl_s2.oor;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##3 done)
		else $error("accepted item did not produce a result after three cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 3))
		else $error("result strobe without a matching accepted item");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_of_range) |-> (sine_value == '0 && cosine_value == '0))
		else $error("out-of-range item gave nonzero results");

endmodule

>>> src/scdl_rom.sv
// Dual-read synchronous ROM holding the quarter-wave sine table.
// Read data is registered. Depends on scdl_pkg.
module scdl_rom
	import scdl_pkg::*;
(
	input  logic              clk,
	input  logic [IDX_W-1:0]  addr_a,
	input  logic [IDX_W-1:0]  addr_b,
	output logic [WORD_W-1:0] data_a,
	output logic [WORD_W-1:0] data_b
);

	always_ff @(posedge clk) begin
		data_a <= QW_TABLE[addr_a];
		data_b <= QW_TABLE[addr_b];
	end

endmodule
